// ===== rtl/zpf_pkg.sv =====
`timescale 1ns / 1ps

package zpf_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int PIXEL_W   = 16;
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 1;
   localparam int SUM_W     = PIXEL_W + 2;

   localparam logic [CFG_W-1:0] FRAME_DIM_RESET = 11'd1024;

   // floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for x < 2**19
   localparam int             RECIP3_SHIFT = 20;
   localparam int             RECIP3_W     = 19;
   localparam logic [RECIP3_W-1:0] RECIP3  = 19'd349526;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] center;
      logic [PIXEL_W-1:0] up;
      logic [PIXEL_W-1:0] down;
      logic [PIXEL_W-1:0] left;
      logic [PIXEL_W-1:0] right;
   } nbr_type;

endpackage

// ===== rtl/zpf_mean.sv =====
`timescale 1ns / 1ps

module zpf_mean (
   input  logic                          clock,
   input  logic                          load,
   input  zpf_pkg::nbr_type              nbr,
   output logic [zpf_pkg::PIXEL_W-1:0]   mean
);
   import zpf_pkg::*;

   logic                 pass_ff;
   logic                 pass_in;
   logic [PIXEL_W-1:0]   center_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [SUM_W-1:0]     sum_in;
   logic [2:0]           cnt_ff;
   logic [2:0]           cnt_in;
   logic [SUM_W+RECIP3_W-1:0] prod;

   always_comb begin
      sum_in  = '0;
      cnt_in  = '0;
      pass_in = (nbr.center != '0);
      if (nbr.up != '0) begin
         sum_in = sum_in + SUM_W'(nbr.up);
         cnt_in = cnt_in + 3'd1;
      end
      if (nbr.down != '0) begin
         sum_in = sum_in + SUM_W'(nbr.down);
         cnt_in = cnt_in + 3'd1;
      end
      if (nbr.left != '0) begin
         sum_in = sum_in + SUM_W'(nbr.left);
         cnt_in = cnt_in + 3'd1;
      end
      if (nbr.right != '0) begin
         sum_in = sum_in + SUM_W'(nbr.right);
         cnt_in = cnt_in + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pass_ff   <= pass_in;
         center_ff <= nbr.center;
         sum_ff    <= sum_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign prod = (SUM_W+RECIP3_W)'(sum_ff) * (SUM_W+RECIP3_W)'(RECIP3);

   always_comb begin
      if (pass_ff) begin
         mean = center_ff;
      end else begin
         case (cnt_ff)
            3'd1:    mean = sum_ff[PIXEL_W-1:0];
            3'd2:    mean = sum_ff[PIXEL_W:1];
            3'd3:    mean = prod[RECIP3_SHIFT+PIXEL_W-1:RECIP3_SHIFT];
            3'd4:    mean = sum_ff[PIXEL_W+1:2];
            default: mean = '0;
         endcase
      end
   end

endmodule

// ===== rtl/zero_pixel_neighbor_mean_fill_unit.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake         Payload
// req      in         req_valid/stall   req_kind, req_pixel
// rsp      out        rsp_valid/stall   rsp_value, rsp_frame_end
// csr      in         csr_wr_en         csr_index, csr_data
//
// A first-row pixel passes through the calculation state only; any other pixel or flush
// request also passes the emit state and waits there on rsp_stall. A request that does
// nothing leaves the unit idle. The row memories are read into registers while idle.
// Reset clears the counters and the output valid; the row memories are not cleared.
// req_stall is high while a request is in process; rsp_stall holds the output register.
module zero_pixel_neighbor_mean_fill_unit #(
   parameter int MAX_WIDTH  = zpf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = zpf_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_kind,
   input  logic [zpf_pkg::PIXEL_W-1:0]     req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [zpf_pkg::PIXEL_W-1:0]     rsp_value,
   output logic                            rsp_frame_end,
   input  logic                            csr_wr_en,
   input  logic [zpf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [zpf_pkg::CFG_W-1:0]       csr_data
);
   import zpf_pkg::*;

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

   state_type            state_ff;
   state_type            state_in;
   logic [CFG_W-1:0]     frame_width_ff;
   logic [CFG_W-1:0]     frame_width_in;
   logic [CFG_W-1:0]     frame_height_ff;
   logic [CFG_W-1:0]     frame_height_in;
   logic [ROW_W-1:0]     in_row_ff;
   logic [ROW_W-1:0]     in_row_in;
   logic [COL_W-1:0]     in_col_ff;
   logic [COL_W-1:0]     in_col_in;
   logic [COL_W-1:0]     out_col_ff;
   logic [COL_W-1:0]     out_col_in;
   logic                 flushing_ff;
   logic                 flushing_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [PIXEL_W-1:0]   rsp_value_ff;
   logic                 rsp_frame_end_ff;

   logic [COL_W-1:0]     col_ff;
   logic [PIXEL_W-1:0]   pixel_ff;
   logic                 emit_ff;
   logic                 has_above_ff;
   logic                 has_left_ff;
   logic                 has_right_ff;
   logic                 last_ff;
   logic                 write_ff;
   logic [PIXEL_W-1:0]   left_ff;

   logic [PIXEL_W-1:0]   mid0_ff;
   logic [PIXEL_W-1:0]   mid1_ff;
   logic [PIXEL_W-1:0]   above_ff;
   logic [PIXEL_W-1:0]   mid_mem   [MAX_WIDTH];
   logic [PIXEL_W-1:0]   above_mem [MAX_WIDTH];

   logic [WID_W-1:0]     w_eff;
   logic [ROW_W-1:0]     h_eff;
   logic [WID_W-1:0]     in_colp1;
   logic [WID_W-1:0]     out_colp1;
   logic [WID_W-1:0]     rd_colp1;
   logic [ROW_W-1:0]     in_rowp1;
   logic                 pix_ok;
   logic                 flush_ok;
   logic                 capture;
   logic                 rsp_load;
   logic [COL_W-1:0]     rd_col;
   logic [COL_W-1:0]     rd_col_nx;
   nbr_type              nbr;
   logic [PIXEL_W-1:0]   mean;

   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = WID_W'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         h_eff = ROW_W'(1);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         h_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         h_eff = ROW_W'(frame_height_ff);
      end
   end

   assign in_colp1  = WID_W'(in_col_ff) + WID_W'(1);
   assign out_colp1 = WID_W'(out_col_ff) + WID_W'(1);
   assign in_rowp1  = in_row_ff + ROW_W'(1);
   assign pix_ok    = !req_kind && !flushing_ff && (WID_W'(in_col_ff) < w_eff)
                      && (in_row_ff < h_eff);
   assign flush_ok  = req_kind && flushing_ff && (WID_W'(out_col_ff) < w_eff);
   assign rd_col    = req_kind ? out_col_ff : in_col_ff;
   assign rd_colp1  = WID_W'(rd_col) + WID_W'(1);
   assign rd_col_nx = (rd_colp1 >= WID_W'(MAX_WIDTH)) ? '0 : COL_W'(rd_colp1);
   assign req_stall = (state_ff != ST_IDLE);
   assign capture   = req_valid && (state_ff == ST_IDLE) && (pix_ok || flush_ok);

   always_comb begin
      state_in        = state_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      in_row_in       = in_row_ff;
      in_col_in       = in_col_ff;
      out_col_in      = out_col_ff;
      flushing_in     = flushing_ff;
      rsp_load        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && pix_ok) begin
               state_in = ST_CALC;
               if (in_colp1 >= w_eff) begin
                  in_col_in = '0;
                  in_row_in = in_rowp1;
                  if (in_rowp1 >= h_eff) begin
                     flushing_in = 1'b1;
                     out_col_in  = '0;
                  end
               end else begin
                  in_col_in = COL_W'(in_colp1);
               end
            end else if (req_valid && flush_ok) begin
               state_in = ST_CALC;
               if (out_colp1 >= w_eff) begin
                  in_row_in   = '0;
                  in_col_in   = '0;
                  out_col_in  = '0;
                  flushing_in = 1'b0;
               end else begin
                  out_col_in = COL_W'(out_colp1);
               end
            end
         end
         ST_CALC: begin
            state_in = emit_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            default: begin
            end
         endcase
         in_row_in   = '0;
         in_col_in   = '0;
         out_col_in  = '0;
         flushing_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_width_ff  <= FRAME_DIM_RESET;
         frame_height_ff <= FRAME_DIM_RESET;
         in_row_ff       <= '0;
         in_col_ff       <= '0;
         out_col_ff      <= '0;
         flushing_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         in_row_ff       <= in_row_in;
         in_col_ff       <= in_col_in;
         out_col_ff      <= out_col_in;
         flushing_ff     <= flushing_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         col_ff       <= rd_col;
         pixel_ff     <= req_pixel;
         write_ff     <= pix_ok;
         emit_ff      <= flush_ok || (in_row_ff != '0);
         has_above_ff <= req_kind ? (h_eff != ROW_W'(1)) : (in_row_ff > ROW_W'(1));
         has_left_ff  <= (rd_col != '0);
         has_right_ff <= (rd_colp1 < w_eff);
         last_ff      <= flush_ok && (out_colp1 >= w_eff);
      end
      if (state_ff == ST_CALC && emit_ff) begin
         left_ff <= mid0_ff;
      end
      if (rsp_load) begin
         rsp_value_ff     <= mean;
         rsp_frame_end_ff <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         mid0_ff  <= mid_mem[rd_col];
         mid1_ff  <= mid_mem[rd_col_nx];
         above_ff <= above_mem[rd_col];
      end
      if (state_ff == ST_CALC && write_ff) begin
         mid_mem[col_ff]   <= pixel_ff;
         above_mem[col_ff] <= mid0_ff;
      end
   end

   always_comb begin
      nbr.center = mid0_ff;
      nbr.up     = has_above_ff ? above_ff : '0;
      nbr.down   = write_ff ? pixel_ff : '0;
      nbr.left   = has_left_ff ? left_ff : '0;
      nbr.right  = has_right_ff ? mid1_ff : '0;
   end

   zpf_mean u_mean (
      .clock (clock),
      .load  (state_ff == ST_CALC),
      .nbr   (nbr),
      .mean  (mean)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   a_emit_needs_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> emit_ff)
      else $error("emit state without a pending result");

   a_flush_after_last_row: assert property (@(posedge clock) disable iff (reset)
      flushing_ff |-> (in_row_ff >= h_eff))
      else $error("flushing before the last row was taken");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result loaded outside the emit state");

   a_cols_in_range: assert property (@(posedge clock) disable iff (reset)
      (WID_W'(in_col_ff) < w_eff) && (WID_W'(out_col_ff) < w_eff))
      else $error("column counter beyond frame width");

endmodule
